[hdl/bracket_mismatch_repair_unit_assert.svh]
// ----------------------------------------------------------------------------
// bracket mismatch repair unit - assertion macros
// concurrent assertion helpers, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef BRACKET_MISMATCH_REPAIR_UNIT_ASSERT_SVH
`define BRACKET_MISMATCH_REPAIR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define BMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BMR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/bmr_pkg.sv]
// ----------------------------------------------------------------------------
// bmr_pkg
// shared constants, types and the closer repair table
// ----------------------------------------------------------------------------
package bmr_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int KIND_W      = 2;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [7:0]        char_t;

	localparam kind_t KIND_PAREN  = 2'd0;
	localparam kind_t KIND_SQUARE = 2'd1;
	localparam kind_t KIND_CURLY  = 2'd2;

	localparam char_t CH_LPAREN  = 8'h28;
	localparam char_t CH_RPAREN  = 8'h29;
	localparam char_t CH_LSQUARE = 8'h5B;
	localparam char_t CH_RSQUARE = 8'h5D;
	localparam char_t CH_LCURLY  = 8'h7B;
	localparam char_t CH_RCURLY  = 8'h7D;
	localparam char_t CH_SPACE   = 8'h20;

	// item in flight between the stack stage and the output stage
	typedef struct packed {
		char_t ch;
		logic  pop;
		logic  ovf;
	} s1_t;

	// rewrite a closer from the kind popped off the stack
	function automatic char_t repair_closer(input char_t closer, input kind_t kind);
		char_t res;
		res = closer;
		case (closer)
			CH_RPAREN: begin
				if (kind == KIND_CURLY)       res = CH_SPACE;
				else if (kind == KIND_SQUARE) res = CH_RSQUARE;
			end
			CH_RCURLY: begin
				if (kind == KIND_PAREN)       res = CH_RPAREN;
				else if (kind == KIND_SQUARE) res = CH_RSQUARE;
			end
			CH_RSQUARE: begin
				if (kind == KIND_PAREN)       res = CH_RPAREN;
				else if (kind == KIND_CURLY)  res = CH_SPACE;
			end
			default: res = closer;
		endcase
		return res;
	endfunction

endpackage

[hdl/bmr_if.sv]
// ----------------------------------------------------------------------------
// bmr channel interfaces
// valid/ready channels for text bytes in and repaired bytes out
// ----------------------------------------------------------------------------
interface bmr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface bmr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       overflow;

	modport source (output valid, output char_out, output overflow, input ready);
	modport sink   (input valid, input char_out, input overflow, output ready);
endinterface

[hdl/bmr_ram.sv]
// ----------------------------------------------------------------------------
// bmr_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bmr_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/bmr_issue.sv]
// ----------------------------------------------------------------------------
// bmr_issue
// decodes incoming bytes, keeps the stack count, pushes and issues pops
// ----------------------------------------------------------------------------
`include "bracket_mismatch_repair_unit_assert.svh"

module bmr_issue import bmr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bmr_in_if.sink    text_in,
	input  logic      s1_take,
	output logic      s1_valid,
	output s1_t       s1_data,
	output kind_t     top_kind
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_m1;
	logic             s1_valid_q;
	s1_t              s1_q;
	logic             acc;
	logic             is_open;
	logic             is_close;
	logic             is_full;
	logic             is_empty;
	logic             push;
	logic             pop;
	kind_t            kind;

	assign text_in.ready = !s1_valid_q || s1_take;
	assign acc           = text_in.valid && text_in.ready;

	always_comb begin
		is_open  = 1'b1;
		is_close = 1'b0;
		kind     = KIND_PAREN;
		case (text_in.char_in)
			CH_LPAREN:  kind = KIND_PAREN;
			CH_LSQUARE: kind = KIND_SQUARE;
			CH_LCURLY:  kind = KIND_CURLY;
			default: begin
				is_open  = 1'b0;
				is_close = text_in.char_in inside {CH_RPAREN, CH_RSQUARE, CH_RCURLY};
			end
		endcase
	end

	assign is_full  = count_q == CNT_W'(STACK_DEPTH);
	assign is_empty = count_q == '0;
	assign push     = acc && is_open && !is_full;
	assign pop      = acc && is_close && !is_empty;
	assign count_m1 = count_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (push) begin
				count_q <= count_q + 1'b1;
			end else if (pop) begin
				count_q <= count_m1;
			end
			if (acc) begin
				// closer on an empty stack is dropped here
				s1_valid_q <= !(is_close && is_empty);
			end else if (s1_take) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_q.ch  <= text_in.char_in;
			s1_q.pop <= is_close;
			s1_q.ovf <= is_open && is_full;
		end
	end

	// a push is written at the edge of its transaction, so a pop in the
	// next cycle already reads the new entry
	bmr_ram #(
		.WIDTH (KIND_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (kind),
		.rd_en   (pop),
		.rd_addr (count_m1[ADDR_W-1:0]),
		.rd_data (top_kind)
	);

	assign s1_valid = s1_valid_q;
	assign s1_data  = s1_q;

	`BMR_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(STACK_DEPTH))
	`BMR_ASSERT_NEXT(a_push_count, clk, arst_n, push, count_q == $past(count_q) + 1'b1)
	`BMR_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid_q && !s1_take, s1_valid_q && $stable(s1_q))

endmodule

[hdl/bmr_repair.sv]
// ----------------------------------------------------------------------------
// bmr_repair
// rewrites popped closers and holds the result in the output register
// ----------------------------------------------------------------------------
`include "bracket_mismatch_repair_unit_assert.svh"

module bmr_repair import bmr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s1_valid,
	input  s1_t       s1_data,
	input  kind_t     top_kind,
	output logic      s1_take,
	bmr_out_if.source text_out
);

	logic  out_valid_q;
	char_t char_q;
	logic  ovf_q;
	logic  out_is_opener;

	assign s1_take = s1_valid && (!out_valid_q || text_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			out_valid_q <= 1'b1;
		end else if (text_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			char_q <= s1_data.pop ? repair_closer(s1_data.ch, top_kind) : s1_data.ch;
			ovf_q  <= s1_data.ovf;
		end
	end

	assign text_out.valid    = out_valid_q;
	assign text_out.char_out = char_q;
	assign text_out.overflow = ovf_q;

	assign out_is_opener = char_q == CH_LPAREN || char_q == CH_LSQUARE || char_q == CH_LCURLY;

	`BMR_ASSERT_NOW(a_ovf_opener, clk, arst_n, out_valid_q && ovf_q, out_is_opener)
	`BMR_ASSERT_NEXT(a_take_loads, clk, arst_n, s1_take, out_valid_q)

endmodule

[hdl/bracket_mismatch_repair_unit.sv]
// ----------------------------------------------------------------------------
// bracket_mismatch_repair_unit
// repairs mismatched closing brackets against a stack of open bracket kinds
// ----------------------------------------------------------------------------
//
// channel    dir   payload             per transaction
// text_in    in    char_in[7:0]        one source text byte
// text_out   out   char_out[7:0],      passed byte, replacement closer or space;
//                  overflow            overflow set when an opener was not pushed
//
// one byte per cycle while text_out does not stall; each byte is held in the
// stack stage and then in the output register; the stack lives in a 64 x 2 ram,
// pushes write and pops read at the input edge, the popped kind is held in the
// ram output; no clearing pass: the ram is only read below the stack count
// text_in stays ready while text_out stalls until both the stage and the
// output register hold a transaction
// arst_n clears the stack count and all valid flags
//
`include "bracket_mismatch_repair_unit_assert.svh"

module bracket_mismatch_repair_unit import bmr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bmr_in_if.sink    text_in,
	bmr_out_if.source text_out
);

	// handoff between the stack stage and the repair stage
	logic  s1_valid;
	logic  s1_take;
	s1_t   s1_data;
	kind_t top_kind;

	// decode, stack count, stack ram push and pop read
	bmr_issue u_issue (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.s1_take  (s1_take),
		.s1_valid (s1_valid),
		.s1_data  (s1_data),
		.top_kind (top_kind)
	);

	// closer rewrite and output register
	bmr_repair u_repair (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_data  (s1_data),
		.top_kind (top_kind),
		.s1_take  (s1_take),
		.text_out (text_out)
	);

	// a held output with a held stage must block new input transactions
	`BMR_ASSERT_NOW(a_full_backpressure, clk, arst_n, s1_valid && !s1_take, !text_in.ready)

endmodule

[bench/bmr_repair_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmr_repair_checker
// watches both channels of the bracket repair unit, keeps its own bracket
// stack to predict each repaired byte and compares field by field
// ----------------------------------------------------------------------------
module bmr_repair_checker import bmr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	bmr_in_if    text_in,
	bmr_out_if   text_out,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		char_t ch;
		logic  ovf;
	} repaired_t;

	repaired_t repaired_q[$];
	kind_t     open_kinds[STACK_DEPTH];
	int        open_depth;
	int        n_bad = 0;

	assign fail_count = n_bad;

	function automatic kind_t kind_of(input char_t opener);
		case (opener)
			CH_LSQUARE: return KIND_SQUARE;
			CH_LCURLY:  return KIND_CURLY;
			default:    return KIND_PAREN;
		endcase
	endfunction

	function automatic char_t closer_of(input kind_t k);
		case (k)
			KIND_SQUARE: return CH_RSQUARE;
			KIND_CURLY:  return CH_RCURLY;
			default:     return CH_RPAREN;
		endcase
	endfunction

	// a matching closer stays; against a curly, round and square become a
	// space; otherwise the closer of the open kind takes its place
	function automatic char_t mend_closer(input char_t closer, input kind_t k);
		if (closer == closer_of(k))
			return closer;
		if (k == KIND_CURLY)
			return CH_SPACE;
		return closer_of(k);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		repaired_t next_res;
		repaired_t oldest;
		char_t     c;
		if (!arst_n) begin
			open_depth = 0;
			repaired_q.delete();
			pending <= 0;
		end else begin
			if (text_in.valid && text_in.ready) begin
				c = text_in.char_in;
				next_res.ch  = c;
				next_res.ovf = 1'b0;
				case (c)
					CH_LPAREN, CH_LSQUARE, CH_LCURLY: begin
						if (open_depth == STACK_DEPTH) begin
							next_res.ovf = 1'b1;
						end else begin
							open_kinds[open_depth] = kind_of(c);
							open_depth++;
						end
						repaired_q.push_back(next_res);
					end
					CH_RPAREN, CH_RSQUARE, CH_RCURLY: begin
						// empty stack: the closer vanishes
						if (open_depth > 0) begin
							open_depth--;
							next_res.ch = mend_closer(c, open_kinds[open_depth]);
							repaired_q.push_back(next_res);
						end
					end
					default: repaired_q.push_back(next_res);
				endcase
			end
			if (text_out.valid && text_out.ready) begin
				if (repaired_q.size() == 0) begin
					$error("unexpected transaction: char_out %02h overflow %0b",
						text_out.char_out, text_out.overflow);
					n_bad++;
				end else begin
					oldest = repaired_q.pop_front();
					if (text_out.char_out !== oldest.ch) begin
						$error("char_out: expected %02h, actual %02h",
							oldest.ch, text_out.char_out);
						n_bad++;
					end
					if (text_out.overflow !== oldest.ovf) begin
						$error("overflow: expected %0b, actual %0b",
							oldest.ovf, text_out.overflow);
						n_bad++;
					end
				end
			end
			pending <= repaired_q.size();
		end
	end

endmodule

[bench/tb_bracket_mismatch_repair_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bracket_mismatch_repair_unit
// drives text bytes into the bracket repair unit under several idle and
// stall mixes; a checker beside the unit predicts and compares every byte
// ----------------------------------------------------------------------------
module tb_bracket_mismatch_repair_unit import bmr_pkg::*;;

	localparam int ITEMS        = 650;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;

	bmr_in_if  text_in();
	bmr_out_if text_out();

	int    idle_pct;
	int    stall_pct;
	bit    hold_req;
	int    hold_cnt = 0;
	int    n_sent;
	int    fail_count;
	int    pending;
	// openers the unit holds right now, used only to steer the stimulus
	char_t open_q[$];

	bracket_mismatch_repair_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.text_out (text_out)
	);

	bmr_repair_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.text_out   (text_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		#500000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver side: random stalls, plus one long hold-off counted here so
	// the unit fills up and pushes back on text_in
	always @(posedge clk) begin
		if (hold_req && hold_cnt < HOLD_CYCLES) begin
			text_out.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			text_out.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic char_t closing_of(input char_t opener);
		case (opener)
			CH_LSQUARE: return CH_RSQUARE;
			CH_LCURLY:  return CH_RCURLY;
			default:    return CH_RPAREN;
		endcase
	endfunction

	function automatic char_t any_opener();
		case ($urandom_range(2))
			0:       return CH_LPAREN;
			1:       return CH_LSQUARE;
			default: return CH_LCURLY;
		endcase
	endfunction

	function automatic char_t any_closer();
		case ($urandom_range(2))
			0:       return CH_RPAREN;
			1:       return CH_RSQUARE;
			default: return CH_RCURLY;
		endcase
	endfunction

	// mostly the matching closer, sometimes a mismatch to exercise repair
	function automatic char_t likely_closer();
		if (open_q.size() > 0 && $urandom_range(99) < 75)
			return closing_of(open_q[$]);
		return any_closer();
	endfunction

	function automatic char_t plain_char();
		int r;
		r = $urandom_range(99);
		if (r < 60) return char_t'($urandom_range(8'h61, 8'h7A));
		if (r < 75) return CH_SPACE;
		if (r < 85) return 8'h0A;
		return char_t'($urandom_range(8'h30, 8'h3D));
	endfunction

	// one transaction on text_in, with random idle cycles in front
	task automatic send_char(input char_t c);
		while ($urandom_range(99) < idle_pct) begin
			text_in.valid <= 1'b0;
			@(posedge clk);
		end
		text_in.valid   <= 1'b1;
		text_in.char_in <= c;
		@(posedge clk);
		while (!text_in.ready) @(posedge clk);
		case (c)
			CH_LPAREN, CH_LSQUARE, CH_LCURLY: begin
				if (open_q.size() < STACK_DEPTH) open_q.push_back(c);
			end
			CH_RPAREN, CH_RSQUARE, CH_RCURLY: begin
				if (open_q.size() > 0) void'(open_q.pop_back());
			end
			default: ;
		endcase
		n_sent++;
	endtask

	// sender goes quiet until every expected byte has come out
	task automatic wait_drained();
		text_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// code-like text with nesting, some mismatched closers
	task automatic send_code(input int len);
		int r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 20)
				send_char(any_opener());
			else if (r < 40 && open_q.size() > 0)
				send_char(likely_closer());
			else
				send_char(plain_char());
		end
		// sometimes unwind fully so the stack returns to empty
		if ($urandom_range(1) == 0)
			while (open_q.size() > 0) send_char(likely_closer());
	endtask

	// deep nesting, past the stack limit when n is large enough
	task automatic send_deep(input int n);
		for (int i = 0; i < n; i++) begin
			send_char(any_opener());
			if ($urandom_range(9) == 0) send_char(plain_char());
		end
		for (int i = 0; i < n + $urandom_range(3); i++)
			send_char(likely_closer());
	endtask

	task automatic send_noise(input int len);
		for (int i = 0; i < len; i++)
			send_char(char_t'($urandom_range(255)));
	endtask

	task automatic run_phase(input int idle, input int stall, input int target);
		int r;
		idle_pct  = idle;
		stall_pct = stall;
		while (n_sent < target) begin
			r = $urandom_range(99);
			if (r < 60)
				send_code($urandom_range(6, 24));
			else if (r < 68)
				send_deep($urandom_range(30, 75));
			else if (r < 90)
				send_noise($urandom_range(3, 15));
			else
				for (int i = 0; i < $urandom_range(1, 4); i++) send_char(any_closer());
			if ($urandom_range(15) == 0) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		char_t openers[3];
		char_t closers[3];
		openers = '{CH_LPAREN, CH_LSQUARE, CH_LCURLY};
		closers = '{CH_RPAREN, CH_RSQUARE, CH_RCURLY};
		arst_n          = 1'b0;
		text_in.valid   = 1'b0;
		text_in.char_in = '0;
		idle_pct        = 0;
		stall_pct       = 0;
		hold_req        = 1'b0;
		n_sent          = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, newline, closer on an empty stack,
		// then every closer against every opener kind
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h0A);
		send_char(CH_RPAREN);
		foreach (openers[i])
			foreach (closers[j]) begin
				send_char(openers[i]);
				send_char(closers[j]);
			end
		wait_drained();

		// long receiver hold-off while the sender keeps pushing a deep run
		// that also overflows the stack
		hold_req <= 1'b1;
		send_deep(STACK_DEPTH + 6);
		wait_drained();

		// random text under each idle and stall mix
		run_phase(0,  0,  n_sent + ITEMS / 4);
		run_phase(70, 0,  n_sent + ITEMS / 4);
		run_phase(0,  70, n_sent + ITEMS / 4);
		run_phase(6,  6,  n_sent + ITEMS / 4);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
